// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared codes and types for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EVENT = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_START      = 4'd0,
        ST_RSTART     = 4'd1,
        ST_SLAW_ACK   = 4'd2,
        ST_SLAW_NACK  = 4'd3,
        ST_DW_ACK     = 4'd4,
        ST_DW_NACK    = 4'd5,
        ST_LOST       = 4'd6,
        ST_SLAR_ACK   = 4'd7,
        ST_SLAR_NACK  = 4'd8,
        ST_DR_ACK     = 4'd9,
        ST_DR_NACK    = 4'd10,
        ST_NONE       = 4'd11
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_AW   = 3'd1,
        PH_AR   = 3'd2,
        PH_WR   = 3'd3,
        PH_RD   = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        CFG_ADDR = 2'd0,
        CFG_MODE = 2'd1,
        CFG_LEN  = 2'd2
    } t_cfg_reg;

    localparam int COUNT_W = 9;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_TDATA_W = 32;

    typedef struct packed {
        logic       drive_data;
        logic [7:0] data_out;
        logic       start_set;
        logic       start_clear;
        logic       stop_set;
        logic       ack_set;
        logic       ack_clear;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic       done_res;
        t_phase     phase;
    } t_result;

endpackage

// ===== rtl/i2c_master_transfer_sequencer_core.sv =====
// Path: an accepted item is held in the input register and moves into the result
// register once that is empty or being taken; it is then valid on o_m_*.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset (synchronous, active low): phase idle, byte count zero, configuration registers 0;
// write buffer contents are not cleared.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// I2C master byte sequencer driven by bus status events.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core #(
    parameter int BUF_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] buf_index, [15:8] buf_byte, [19:16] status_code, [27:20] rx_byte
    input  logic [31:0] i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_tuser,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] drive_data, [8:1] data_out, [9] start_set, [10] start_clear,
    // [11] stop_set, [12] ack_set, [13] ack_clear, [14] rx_valid,
    // [22:15] rx_index, [30:23] rx_data, [31] done_res, [34:32] phase
    output logic [39:0] o_m_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    // byte_count is 9 bits, so no more than 512 buffer entries are reachable
    localparam int MEM_DEPTH = (BUF_DEPTH < 512) ? BUF_DEPTH : 512;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LAST      = MEM_DEPTH - 1;

    // ---------------- configuration ----------------
    logic [7:0] r_addr_byte;
    logic       r_read_mode;
    logic [8:0] r_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_byte <= 8'd0;
            r_read_mode <= 1'b0;
            r_len       <= 9'd0;
        end else if (i_cfg_valid) begin
            unique case (i2cms_pkg::t_cfg_reg'(i_cfg_index))
                i2cms_pkg::CFG_ADDR: r_addr_byte <= i_cfg_data[7:0];
                i2cms_pkg::CFG_MODE: r_read_mode <= i_cfg_data[0];
                i2cms_pkg::CFG_LEN:  r_len       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic       r_in_vld;
    logic [1:0] r_in_cmd;
    logic [7:0] r_in_bidx;
    logic [7:0] r_in_bbyte;
    logic [3:0] r_in_status;
    logic [7:0] r_in_rxb;

    logic r_out_vld;
    logic w_fire;

    assign w_fire     = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_cmd    <= i_s_tuser;
            r_in_bidx   <= i_s_tdata[7:0];
            r_in_bbyte  <= i_s_tdata[15:8];
            r_in_status <= i_s_tdata[19:16];
            r_in_rxb    <= i_s_tdata[27:20];
        end
    end

    // ---------------- buffer index reduction ----------------
    logic [AW-1:0] w_mod_tab [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_mod
        localparam int MODV = gi % BUF_DEPTH;
        assign w_mod_tab[gi] = AW'(MODV);
    end

    // ---------------- sequencer state ----------------
    i2cms_pkg::t_phase r_phase, n_phase;
    logic [8:0]        r_count, n_count;
    logic [AW-1:0]     r_widx, n_widx;     // r_count modulo BUF_DEPTH
    logic [7:0]        w_mem_q;
    logic              w_we;
    logic [8:0]        w_count_inc;
    logic [AW-1:0]     w_widx_inc;
    i2cms_pkg::t_result w_res, r_out;

    assign w_count_inc = r_count + 9'd1;
    assign w_widx_inc  = ((r_count == 9'h1FF) || (r_widx == AW'(LAST))) ? '0
                                                                          : r_widx + AW'(1);

    i2cms_wbuf #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_mod_tab[r_in_bidx]),
        .i_wdata (r_in_bbyte),
        .i_raddr (n_widx),
        .o_rdata (w_mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cms_pkg::PH_IDLE;
            r_count <= 9'd0;
            r_widx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_widx  <= n_widx;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_widx  = r_widx;
        w_we    = 1'b0;
        w_res   = '0;
        if (w_fire) begin
            unique case (i2cms_pkg::t_cmd'(r_in_cmd))
                i2cms_pkg::CMD_LOAD: begin
                    w_we = 1'b1;
                end
                i2cms_pkg::CMD_START: begin
                    n_count         = 9'd0;
                    n_widx          = '0;
                    w_res.start_set = 1'b1;
                end
                i2cms_pkg::CMD_EVENT: begin
                    unique case (i2cms_pkg::t_status'(r_in_status))
                        i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                            w_res.drive_data  = 1'b1;
                            w_res.start_clear = 1'b1;
                            if (r_read_mode) begin
                                w_res.data_out = r_addr_byte | 8'h01;
                                n_phase        = i2cms_pkg::PH_AR;
                            end else begin
                                w_res.data_out = r_addr_byte;
                                n_phase        = i2cms_pkg::PH_AW;
                            end
                        end
                        i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_DW_ACK: begin
                            if (i2cms_pkg::t_status'(r_in_status) == i2cms_pkg::ST_SLAW_ACK) begin
                                n_phase = i2cms_pkg::PH_WR;
                            end
                            if (r_count < r_len) begin
                                w_res.drive_data = 1'b1;
                                w_res.data_out   = w_mem_q;
                                w_res.ack_set    = 1'b1;
                                n_count          = w_count_inc;
                                n_widx           = w_widx_inc;
                            end else begin
                                w_res.stop_set = 1'b1;
                                w_res.done_res = 1'b1;
                                n_phase        = i2cms_pkg::PH_IDLE;
                            end
                        end
                        i2cms_pkg::ST_SLAR_ACK: begin
                            n_phase       = i2cms_pkg::PH_RD;
                            w_res.ack_set = 1'b1;
                        end
                        i2cms_pkg::ST_DR_ACK: begin
                            w_res.rx_valid = 1'b1;
                            w_res.rx_index = r_count[7:0];
                            w_res.rx_data  = r_in_rxb;
                            n_count        = w_count_inc;
                            n_widx         = w_widx_inc;
                            if (w_count_inc < r_len) begin
                                w_res.ack_set = 1'b1;
                            end else begin
                                w_res.ack_clear = 1'b1;
                                w_res.done_res  = 1'b1;
                                n_phase         = i2cms_pkg::PH_IDLE;
                            end
                        end
                        i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_SLAR_NACK: begin
                            n_phase           = i2cms_pkg::PH_ERR;
                            w_res.start_clear = 1'b1;
                            w_res.stop_set    = 1'b1;
                        end
                        i2cms_pkg::ST_DW_NACK, i2cms_pkg::ST_LOST,
                        i2cms_pkg::ST_DR_NACK: begin
                            n_phase        = i2cms_pkg::PH_IDLE;
                            w_res.stop_set = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        w_res.phase = n_phase;
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out.phase, r_out.done_res, r_out.rx_data, r_out.rx_index,
                         r_out.rx_valid, r_out.ack_clear, r_out.ack_set, r_out.stop_set,
                         r_out.start_clear, r_out.start_set, r_out.data_out,
                         r_out.drive_data};

    // ---------------- assertions ----------------
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.done_res |-> r_out.phase == i2cms_pkg::PH_IDLE)
        else $error("done without return to idle");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 9'd0 |-> r_widx == '0)
        else $error("buffer index out of step with byte count");

    a_rx_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.rx_valid |->
            !r_out.drive_data && (r_out.ack_set != r_out.ack_clear))
        else $error("receive result also drives transmit data");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_fire |=> r_in_vld)
        else $error("pending item dropped");

endmodule

// ===== rtl/i2cms_wbuf.sv =====
// ----------------------------------------------------------------------------
// i2cms_wbuf
// Write buffer: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module i2cms_wbuf #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // same-cycle write to the read address returns the new byte
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/i2c_master_transfer_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core_tb
// Drives load, start-request and bus-status transactions into the sequencer
// and checks every result against an in-bench model of the transfer phases,
// byte counter and write buffer. Directed corner cases first, then
// randomized write and read transfers mixed with noise, under random
// valid/ready gaps and several register settings.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core_tb;

    localparam int ITEM_GOAL    = 1850;
    localparam int PHASE_ITEMS  = 120;
    localparam int WRAP_RUN     = 520;
    localparam int STALL_LIMIT  = 1000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [3:0] ST_TOP     = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] buf_index;
        logic [7:0] buf_byte;
        logic [3:0] status;
        logic [7:0] rx_byte;
    } t_seq_input;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;

    // bench-side copy of the sequencer state and registers
    i2cms_pkg::t_phase seq_phase = i2cms_pkg::PH_IDLE;
    logic [8:0]  xfer_count = '0;
    logic [7:0]  tx_bytes [256];
    logic [7:0]  cfg_addr_q = '0;
    logic        cfg_read_q = 1'b0;
    logic [8:0]  cfg_len_q = '0;

    // stimulus bookkeeping
    t_seq_input          queued_cmds [$];
    i2cms_pkg::t_result  expected_reactions [$];
    t_seq_input          next_cmd;
    i2cms_pkg::t_result  got_reaction;
    i2cms_pkg::t_result  want_reaction;
    bit          loaded_idx [256];
    bit          gen_read;
    int          gen_len;
    bit          steady;
    bit          in_fire;
    int          send_gap;
    int          recv_gap;
    int          pushed_total;
    int          accepted_total;
    int          counted_items;
    int          mismatches;
    int          quiet_cycles;

    i2c_master_transfer_sequencer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic i2cms_pkg::t_result predict_sequencer_reaction(t_seq_input it);
        i2cms_pkg::t_result r;
        bit      finished;
        r = '0;
        finished = 1'b0;
        case (it.cmd)
            i2cms_pkg::CMD_LOAD: tx_bytes[it.buf_index] = it.buf_byte;
            i2cms_pkg::CMD_START: begin
                xfer_count = '0;
                r.start_set = 1'b1;
            end
            i2cms_pkg::CMD_EVENT: begin
                case (it.status)
                    i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                        r.drive_data = 1'b1;
                        r.data_out = cfg_read_q ? (cfg_addr_q | 8'h01) : cfg_addr_q;
                        r.start_clear = 1'b1;
                        seq_phase = cfg_read_q ? i2cms_pkg::PH_AR : i2cms_pkg::PH_AW;
                    end
                    i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_DW_ACK: begin
                        if (it.status == i2cms_pkg::ST_SLAW_ACK) seq_phase = i2cms_pkg::PH_WR;
                        if (xfer_count < cfg_len_q) begin
                            r.drive_data = 1'b1;
                            r.data_out = tx_bytes[xfer_count[7:0]];
                            r.ack_set = 1'b1;
                            xfer_count = xfer_count + 9'd1;
                        end else begin
                            r.stop_set = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    i2cms_pkg::ST_SLAR_ACK: begin
                        seq_phase = i2cms_pkg::PH_RD;
                        r.ack_set = 1'b1;
                    end
                    i2cms_pkg::ST_DR_ACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = xfer_count[7:0];
                        r.rx_data = it.rx_byte;
                        xfer_count = xfer_count + 9'd1;   // wraps in 9 bits
                        if (xfer_count < cfg_len_q) begin
                            r.ack_set = 1'b1;
                        end else begin
                            r.ack_clear = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_SLAR_NACK: begin
                        seq_phase = i2cms_pkg::PH_ERR;
                        r.start_clear = 1'b1;
                        r.stop_set = 1'b1;
                    end
                    i2cms_pkg::ST_DW_NACK, i2cms_pkg::ST_LOST, i2cms_pkg::ST_DR_NACK: begin
                        seq_phase = i2cms_pkg::PH_IDLE;
                        r.stop_set = 1'b1;
                    end
                    default: ;
                endcase
                if (finished) begin
                    seq_phase = i2cms_pkg::PH_IDLE;
                    r.done_res = 1'b1;
                end
            end
            default: ;
        endcase
        r.phase = seq_phase;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_item(logic [1:0] cmd, logic [3:0] code, logic [7:0] idx,
                                       logic [7:0] val, logic [7:0] rx);
        t_seq_input it;
        it.cmd = cmd;
        it.buf_index = idx;
        it.buf_byte = val;
        it.status = code;
        it.rx_byte = rx;
        if (cmd == i2cms_pkg::CMD_LOAD) loaded_idx[idx] = 1'b1;
        // ignored transactions do not count toward the item goal
        if (!(cmd == CMD_UNUSED || (cmd == i2cms_pkg::CMD_EVENT && code >= i2cms_pkg::ST_NONE)))
            counted_items++;
        queued_cmds.push_back(it);
        pushed_total++;
    endfunction

    function automatic void queue_event(logic [3:0] code);
        queue_item(i2cms_pkg::CMD_EVENT, code, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic void queue_load(logic [7:0] idx, logic [7:0] val);
        queue_item(i2cms_pkg::CMD_LOAD, 4'($urandom), idx, val, 8'($urandom));
    endfunction

    function automatic void queue_start();
        queue_item(i2cms_pkg::CMD_START, 4'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
    endfunction

    function automatic void queue_noise();
        queue_item(2'($urandom_range(i2cms_pkg::CMD_LOAD, CMD_UNUSED)),
                   4'($urandom_range(i2cms_pkg::ST_START, ST_TOP)),
                   8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // one bus transfer in the current direction; clean transfers never break off
    function automatic void queue_transfer(bit clean);
        int k;
        int n;
        if (!gen_read && gen_len > 0 && $urandom_range(0, 2) == 0)
            queue_load(8'($urandom_range(0, gen_len - 1)), 8'($urandom));
        queue_start();
        queue_event($urandom_range(0, 3) == 0 ? i2cms_pkg::ST_RSTART : i2cms_pkg::ST_START);
        if (!gen_read) begin
            if (!clean && $urandom_range(0, 9) == 0) begin
                queue_event(i2cms_pkg::ST_SLAW_NACK);
                return;
            end
            queue_event(i2cms_pkg::ST_SLAW_ACK);
            for (k = 0; k < gen_len; k++) begin
                if (!clean && $urandom_range(0, 39) == 0) begin
                    queue_event($urandom_range(0, 1) ? i2cms_pkg::ST_DW_NACK
                                                     : i2cms_pkg::ST_LOST);
                    return;
                end
                queue_event(i2cms_pkg::ST_DW_ACK);
            end
        end else begin
            if (!clean && $urandom_range(0, 9) == 0) begin
                queue_event(i2cms_pkg::ST_SLAR_NACK);
                return;
            end
            queue_event(i2cms_pkg::ST_SLAR_ACK);
            n = (gen_len == 0) ? 1 : gen_len;
            for (k = 0; k < n; k++) begin
                if (!clean && $urandom_range(0, 39) == 0) begin
                    queue_event($urandom_range(0, 1) ? i2cms_pkg::ST_DR_NACK
                                                     : i2cms_pkg::ST_LOST);
                    return;
                end
                queue_event(i2cms_pkg::ST_DR_ACK);
            end
            if ($urandom_range(0, 1)) queue_event(i2cms_pkg::ST_DR_NACK);
        end
    endfunction

    task automatic wait_idle();
        while (accepted_total != pushed_total || expected_reactions.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(i2cms_pkg::t_cfg_reg idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reprogram while idle, then make sure every index a send can reach is loaded
    task automatic start_phase(logic [7:0] addr, bit rd, int len);
        int i;
        wait_idle();
        write_reg(i2cms_pkg::CFG_ADDR, {1'b0, addr});
        write_reg(i2cms_pkg::CFG_MODE, {8'd0, rd});
        write_reg(i2cms_pkg::CFG_LEN, 9'(len));
        gen_read = rd;
        gen_len = len;
        steady = ($urandom_range(0, 3) == 0) || (counted_items >= ITEM_GOAL - 2 * PHASE_ITEMS);
        for (i = 0; i < len; i++)
            if (!loaded_idx[i]) queue_load(8'(i), 8'($urandom));
    endtask

    // sender and receiver, both change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || !i_s_tvalid) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (queued_cmds.size() != 0) begin
                    next_cmd = queued_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {4'b0, next_cmd.rx_byte, next_cmd.status,
                                  next_cmd.buf_byte, next_cmd.buf_index};
                    i_s_tuser <= next_cmd.cmd;
                    if (!steady && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
            end
        end
    end

    // handshake sampling, prediction and checking on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_fire <= i_s_tvalid && o_s_tready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    i2cms_pkg::CFG_ADDR: cfg_addr_q = i_cfg_data[7:0];
                    i2cms_pkg::CFG_MODE: cfg_read_q = i_cfg_data[0];
                    i2cms_pkg::CFG_LEN:  cfg_len_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_m_tvalid && i_m_tready) begin
                got_reaction.drive_data  = o_m_tdata[0];
                got_reaction.data_out    = o_m_tdata[8:1];
                got_reaction.start_set   = o_m_tdata[9];
                got_reaction.start_clear = o_m_tdata[10];
                got_reaction.stop_set    = o_m_tdata[11];
                got_reaction.ack_set     = o_m_tdata[12];
                got_reaction.ack_clear   = o_m_tdata[13];
                got_reaction.rx_valid    = o_m_tdata[14];
                got_reaction.rx_index    = o_m_tdata[22:15];
                got_reaction.rx_data     = o_m_tdata[30:23];
                got_reaction.done_res    = o_m_tdata[31];
                got_reaction.phase       = i2cms_pkg::t_phase'(o_m_tdata[34:32]);
                if (expected_reactions.size() == 0) begin
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, o_m_tdata);
                    mismatches++;
                end else begin
                    want_reaction = expected_reactions.pop_front();
                    check_field("drive_data", 8'(want_reaction.drive_data),
                                8'(got_reaction.drive_data));
                    check_field("data_out", want_reaction.data_out, got_reaction.data_out);
                    check_field("start_set", 8'(want_reaction.start_set),
                                8'(got_reaction.start_set));
                    check_field("start_clear", 8'(want_reaction.start_clear),
                                8'(got_reaction.start_clear));
                    check_field("stop_set", 8'(want_reaction.stop_set),
                                8'(got_reaction.stop_set));
                    check_field("ack_set", 8'(want_reaction.ack_set),
                                8'(got_reaction.ack_set));
                    check_field("ack_clear", 8'(want_reaction.ack_clear),
                                8'(got_reaction.ack_clear));
                    check_field("rx_valid", 8'(want_reaction.rx_valid),
                                8'(got_reaction.rx_valid));
                    check_field("rx_index", want_reaction.rx_index, got_reaction.rx_index);
                    check_field("rx_data", want_reaction.rx_data, got_reaction.rx_data);
                    check_field("done_res", 8'(want_reaction.done_res),
                                8'(got_reaction.done_res));
                    check_field("phase", 8'(want_reaction.phase), 8'(got_reaction.phase));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_reactions.push_back(predict_sequencer_reaction(
                    {i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[19:16],
                     i_s_tdata[27:20]}));
                accepted_total++;
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int len;
        int phase_base;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: write transfer, buffer extremes, ignored codes, error paths
        start_phase(8'hA4, 1'b0, 2);
        queue_load(8'h00, 8'h00);
        queue_load(8'h01, 8'hFF);
        queue_load(8'hFF, 8'h81);
        queue_item(CMD_UNUSED, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        queue_event(i2cms_pkg::ST_NONE);
        queue_event(ST_TOP);
        queue_start();
        queue_event(i2cms_pkg::ST_START);
        queue_event(i2cms_pkg::ST_SLAW_ACK);
        queue_event(i2cms_pkg::ST_DW_ACK);
        queue_event(i2cms_pkg::ST_DW_ACK);
        queue_start();
        queue_event(i2cms_pkg::ST_RSTART);
        queue_event(i2cms_pkg::ST_SLAW_NACK);
        queue_start();                      // error phase survives a start request
        queue_event(i2cms_pkg::ST_START);
        queue_event(i2cms_pkg::ST_SLAW_ACK);
        queue_event(i2cms_pkg::ST_DW_NACK);
        queue_event(i2cms_pkg::ST_LOST);

        // directed: zero length, read direction, full-scale received bytes
        start_phase(8'hFF, 1'b1, 0);
        queue_event(i2cms_pkg::ST_START);
        queue_event(i2cms_pkg::ST_SLAW_ACK);
        queue_event(i2cms_pkg::ST_SLAR_ACK);
        queue_item(i2cms_pkg::CMD_EVENT, i2cms_pkg::ST_DR_ACK, 8'($urandom), 8'($urandom),
                   8'hFF);
        queue_item(i2cms_pkg::CMD_EVENT, i2cms_pkg::ST_DR_ACK, 8'($urandom), 8'($urandom),
                   8'h00);
        queue_event(i2cms_pkg::ST_SLAR_NACK);
        queue_event(i2cms_pkg::ST_DR_NACK);

        // longest write, then a long read run that wraps the byte counter
        start_phase(8'($urandom), 1'b0, 256);
        queue_transfer(1'b1);
        start_phase(8'h00, 1'b1, 256);
        queue_start();
        queue_event(i2cms_pkg::ST_START);
        queue_event(i2cms_pkg::ST_SLAR_ACK);
        repeat (WRAP_RUN) queue_event(i2cms_pkg::ST_DR_ACK);
        queue_event(i2cms_pkg::ST_DR_NACK);

        while (counted_items < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 1;
                2: len = $urandom_range(9, 40);
                default: len = $urandom_range(2, 8);
            endcase
            start_phase(8'($urandom), 1'($urandom_range(0, 1)), len);
            phase_base = counted_items;
            while (counted_items - phase_base < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7)
                    queue_transfer(1'b0);
                else
                    repeat ($urandom_range(1, 4)) queue_noise();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_reactions.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
